### rtl/assert_macros.svh
// Assertion macros used by the checker file of the hex printer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that is also checked across reset.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed across reset");

`endif

### rtl/fshp_pkg.sv
// Package of the format string hex printer: types, character codes and limits.
`timescale 1ns / 1ps
`default_nettype none

package fshp_pkg;

    // Digit cap: MAX_DIGITS clamped into 1..8, since the argument has eight nibbles.
    localparam int MAX_DIGITS = 8;
    localparam int DIG_CAP    = (MAX_DIGITS > 8) ? 8 : ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int IDX_W      = (DIG_CAP > 1) ? $clog2(DIG_CAP) : 1;

    // Digit cap at the width of the parser's width register.
    localparam logic [3:0] DIG_CAP4 = 4'(DIG_CAP);

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_S  = 8'h73;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    localparam logic [3:0] DEF_WIDTH = 4'd8;

    typedef enum logic [1:0] {
        PM_PLAIN = 2'd0,
        PM_PCT   = 2'd1,
        PM_ZERO  = 2'd2,
        PM_WIDTH = 2'd3
    } t_parse_mode;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_CHAR = 2'd1,
        K_END  = 2'd2,
        K_HEX  = 2'd3
    } t_kind;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EMIT = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic has_result;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/fshp_ctrl.sv
// Controller of the hex printer: takes a request, then emits its results one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module fshp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire fshp_pkg::t_dp_stat i_stat,
    output fshp_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_stall
);

    fshp_pkg::t_ctrl_state r_state;
    fshp_pkg::t_ctrl_state n_state;

    // Hold the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fshp_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Go to emitting on a request with results, and back to idle on its last emitted result.
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            fshp_pkg::CS_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.has_result) begin
                    n_state = fshp_pkg::CS_EMIT;
                end
            end
            fshp_pkg::CS_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = fshp_pkg::CS_IDLE;
                    end
                end
            end
            default: begin
                n_state = fshp_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/fshp_dp.sv
// Datapath of the hex printer: spec parser, request latch, digit counter, output register.
`timescale 1ns / 1ps
`default_nettype none

module fshp_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fshp_pkg::t_dp_cmd  i_cmd,
    output fshp_pkg::t_dp_stat     o_stat,
    input  wire logic [7:0]        i_fmt_char,
    input  wire logic [31:0]       i_arg_value,
    output logic [7:0]             o_out_char,
    output logic                   o_has_char,
    output logic                   o_run_last,
    output logic                   o_end_of_text,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall
);

    // Parser state.
    fshp_pkg::t_parse_mode r_mode;
    fshp_pkg::t_parse_mode n_mode;
    logic [3:0]            r_width;
    logic [3:0]            n_width;
    fshp_pkg::t_kind       kind;

    // Latched request and digit index.
    fshp_pkg::t_kind              r_kind;
    logic [7:0]                   r_char;
    logic [7:0][3:0]              r_arg;
    logic [fshp_pkg::IDX_W-1:0]   r_idx;
    logic [fshp_pkg::IDX_W-1:0]   hex_idx;
    logic [3:0]                   hex_cnt;

    // Output register.
    logic                         r_out_valid;
    logic [7:0]                   r_out_char;
    logic                         r_has_char;
    logic                         r_run_last;
    logic                         r_end_of_text;

    logic                         is_digit;
    logic [3:0]                   nib;
    logic [7:0]                   emit_char;

    assign is_digit = (i_fmt_char > fshp_pkg::CH_ZERO) && (i_fmt_char <= fshp_pkg::CH_EIGHT);

    // Classify the incoming byte and work out the next parser state.
    always_comb begin
        n_mode  = r_mode;
        n_width = r_width;
        kind    = fshp_pkg::K_NONE;
        if (i_fmt_char == fshp_pkg::CH_NUL) begin
            n_mode  = fshp_pkg::PM_PLAIN;
            n_width = fshp_pkg::DEF_WIDTH;
            kind    = fshp_pkg::K_END;
        end else if (r_mode == fshp_pkg::PM_PLAIN) begin
            if (i_fmt_char == fshp_pkg::CH_PCT) begin
                n_mode  = fshp_pkg::PM_PCT;
                n_width = fshp_pkg::DEF_WIDTH;
            end else begin
                kind = fshp_pkg::K_CHAR;
            end
        end else if ((r_mode == fshp_pkg::PM_PCT) && (i_fmt_char == fshp_pkg::CH_ZERO)) begin
            n_mode = fshp_pkg::PM_ZERO;
        end else if ((r_mode != fshp_pkg::PM_WIDTH) && is_digit) begin
            n_mode  = fshp_pkg::PM_WIDTH;
            n_width = 4'(i_fmt_char - fshp_pkg::CH_ZERO);
        end else begin
            // Conversion byte: drop the spec, emit hex unless it is the string form.
            n_mode  = fshp_pkg::PM_PLAIN;
            n_width = fshp_pkg::DEF_WIDTH;
            if (i_fmt_char != fshp_pkg::CH_LC_S) begin
                kind = fshp_pkg::K_HEX;
            end
        end
    end

    // Clamp the digit count to the cap, with at least one digit.
    always_comb begin
        hex_cnt = (r_width > fshp_pkg::DIG_CAP4) ? fshp_pkg::DIG_CAP4 : r_width;
        if (hex_cnt == 4'd0) begin
            hex_idx = '0;
        end else begin
            hex_idx = fshp_pkg::IDX_W'(hex_cnt - 4'd1);
        end
    end

    // Pick the current nibble and map it to lowercase hex.
    always_comb begin
        nib = r_arg[r_idx];
        if (nib < 4'd10) begin
            emit_char = fshp_pkg::CH_ZERO + {4'b0000, nib};
        end else begin
            emit_char = fshp_pkg::CH_LC_A + {4'b0000, nib} - fshp_pkg::HEX_TEN;
        end
    end

    assign o_stat.has_result = (kind != fshp_pkg::K_NONE);
    assign o_stat.last       = (r_idx == '0);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    // Update parser state and request kind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= fshp_pkg::PM_PLAIN;
            r_width <= fshp_pkg::DEF_WIDTH;
            r_kind  <= fshp_pkg::K_NONE;
        end else if (i_cmd.accept) begin
            r_mode  <= n_mode;
            r_width <= n_width;
            r_kind  <= kind;
        end
    end

    // Latch the request and count digits down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_fmt_char;
            r_arg  <= i_arg_value;
            r_idx  <= (kind == fshp_pkg::K_HEX) ? hex_idx : '0;
        end else if (i_cmd.emit && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Hold the output valid flag until the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_run_last    <= (r_idx == '0);
            r_end_of_text <= (r_kind == fshp_pkg::K_END);
            r_has_char    <= (r_kind != fshp_pkg::K_END);
            unique case (r_kind)
                fshp_pkg::K_HEX:  r_out_char <= emit_char;
                fshp_pkg::K_CHAR: r_out_char <= r_char;
                default:          r_out_char <= fshp_pkg::CH_NUL;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_has_char    = r_has_char;
    assign o_run_last    = r_run_last;
    assign o_end_of_text = r_end_of_text;

endmodule

`default_nettype wire

### rtl/format_string_hex_printer.sv
// Top level of the format string hex printer: controller and datapath.
// A request is latched, then its results are loaded into a single output register.
// A request has one result for a plain character or end marker, up to 8 for a hex
// conversion, or none; the input stalls until its last result has been emitted.
// The digit counter emits one result per cycle while the output is not stalled.
// Reset (synchronous, active low): plain-text mode, width 8, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module format_string_hex_printer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_fmt_char,
    input  wire logic [31:0] i_arg_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_char,
    output logic             o_has_char,
    output logic             o_run_last,
    output logic             o_end_of_text
);

    fshp_pkg::t_dp_cmd  cmd;
    fshp_pkg::t_dp_stat stat;

    // Sequence requests and results.
    fshp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Parse, count digits and register the output.
    fshp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_fmt_char    (i_fmt_char),
        .i_arg_value   (i_arg_value),
        .o_out_char    (o_out_char),
        .o_has_char    (o_has_char),
        .o_run_last    (o_run_last),
        .o_end_of_text (o_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall)
    );

endmodule

`default_nettype wire

### rtl/fshp_checker.sv
// Port-level checker of the hex printer and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fshp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_out_char,
    input wire logic        o_has_char,
    input wire logic        o_run_last,
    input wire logic        o_end_of_text
);

    logic [11:0] out_word;
    logic        end_ok;

    // Gather the output side and the end marker form.
    assign out_word = {o_out_valid, o_out_char, o_has_char, o_run_last, o_end_of_text};
    assign end_ok   = o_run_last && !o_has_char && (o_out_char == fshp_pkg::CH_NUL);

    // Stalled result holds.
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(out_word))

    // End marker is a last result with no character.
    `CHK_IMPLY(a_end_form, i_clk, i_rst_n, o_out_valid && o_end_of_text, end_ok)

    // Every result is a character or an end marker, never both.
    `CHK_IMPLY(a_char_xor_end, i_clk, i_rst_n, o_out_valid, o_has_char != o_end_of_text)

    // No new request while a run is still in progress.
    `CHK_IMPLY(a_run_blocks_in, i_clk, i_rst_n, o_out_valid && !o_run_last, o_in_stall)

    // Reset empties the output register.
    `CHK_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind format_string_hex_printer fshp_checker u_chk (.*);

`default_nettype wire
